FILE: src/slcan_frame_command_parser_core_assert.svh
// Assertion macros shared by the parser RTL.
`ifndef SLCAN_FRAME_COMMAND_PARSER_CORE_ASSERT_SVH
`define SLCAN_FRAME_COMMAND_PARSER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SCFP_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SCFP_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/scfp_pkg.sv
// Types and codes shared by the frame command parser modules.
`timescale 1ns / 1ps
package scfp_pkg;

  localparam logic [7:0] CHAR_CR = 8'h0D;

  localparam logic [2:0] KIND_NONE       = 3'd0;
  localparam logic [2:0] KIND_STD_DATA   = 3'd1;
  localparam logic [2:0] KIND_STD_REMOTE = 3'd2;
  localparam logic [2:0] KIND_EXT_DATA   = 3'd3;
  localparam logic [2:0] KIND_EXT_REMOTE = 3'd4;

  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_BAD  = 2'd1;
  localparam logic [1:0] STAT_NONE = 2'd2;

  localparam logic [3:0] STD_ID_DIGITS = 4'd3;
  localparam logic [3:0] EXT_ID_DIGITS = 4'd8;

  // One received byte after decode.
  typedef struct packed {
    logic       is_cr;
    logic [2:0] kind;     // command kind if this byte opens a line
    logic       hex_ok;
    logic [3:0] hex_val;
    logic       len_ok;   // '0' to '8'
    logic [3:0] len_val;
  } cls_t;

  // One parsed line.
  typedef struct packed {
    logic [1:0]  status;
    logic        is_extended;
    logic        is_remote;
    logic [31:0] frame_id;
    logic [3:0]  data_length;
    logic [63:0] payload;
  } res_t;

  // Back end handshake strobes.
  typedef struct packed {
    logic item_pop;
    logic res_push;
  } back_ctl_t;

endpackage

FILE: src/scfp_fifo.sv
// Small first-in first-out queue used between and behind the parser stages.
`timescale 1ns / 1ps
module scfp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             rd_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             wr_en, rd_en;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign wr_en   = wr_i && !full_o;
  assign rd_en   = rd_i && !empty_o;
  assign rdata_o = mem[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_en) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (rd_en) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (wr_en && !rd_en) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (rd_en && !wr_en) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

FILE: src/scfp_classify.sv
// Front end byte decoder: marks line ends, command letters and digit values.
`timescale 1ns / 1ps
module scfp_classify (
  input  logic          [7:0] char_i,
  output scfp_pkg::cls_t      cls_o
);
  import scfp_pkg::*;

  logic [7:0] dig_off, low_off, up_off;

  assign dig_off = char_i - 8'h30;   // '0'
  assign low_off = char_i - 8'h57;   // 'a' - 10
  assign up_off  = char_i - 8'h37;   // 'A' - 10

  always_comb begin
    cls_o         = '0;
    cls_o.is_cr   = (char_i == CHAR_CR);

    priority if (char_i == 8'h74) begin        // t
      cls_o.kind = KIND_STD_DATA;
    end else if (char_i == 8'h72) begin        // r
      cls_o.kind = KIND_STD_REMOTE;
    end else if (char_i == 8'h54) begin        // T
      cls_o.kind = KIND_EXT_DATA;
    end else if (char_i == 8'h52) begin        // R
      cls_o.kind = KIND_EXT_REMOTE;
    end else begin
      cls_o.kind = KIND_NONE;
    end

    priority if (char_i >= 8'h30 && char_i <= 8'h39) begin
      cls_o.hex_ok  = 1'b1;
      cls_o.hex_val = dig_off[3:0];
    end else if (char_i >= 8'h61 && char_i <= 8'h66) begin
      cls_o.hex_ok  = 1'b1;
      cls_o.hex_val = low_off[3:0];
    end else if (char_i >= 8'h41 && char_i <= 8'h46) begin
      cls_o.hex_ok  = 1'b1;
      cls_o.hex_val = up_off[3:0];
    end else begin
      cls_o.hex_ok  = 1'b0;
      cls_o.hex_val = '0;
    end

    cls_o.len_ok  = (char_i >= 8'h30 && char_i <= 8'h38);
    cls_o.len_val = dig_off[3:0];
  end

endmodule

FILE: src/scfp_line.sv
// Back end line parser: forms id, length, payload; one result per line not too long.
`timescale 1ns / 1ps
module scfp_line #(
  parameter int LINE_BYTES = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  item_valid_i,
  input  scfp_pkg::cls_t        item_i,
  input  logic                  res_full_i,
  output scfp_pkg::res_t        res_o,
  output scfp_pkg::back_ctl_t   ctl_o
);
  import scfp_pkg::*;

  localparam int PW = $clog2(LINE_BYTES + 1);

  logic [PW-1:0] pos_q, pos_d, pos_inc, d_full;
  logic [2:0]    kind_q, kind_d;
  logic          bad_q, bad_d, skip_q, skip_d;
  logic [31:0]   id_q, id_d;
  logic [3:0]    len_q, len_d, ndig, nib;
  logic [63:0]   pay_q, pay_d;
  logic          ext, rem, take;

  assign ext     = (kind_q == KIND_EXT_DATA) || (kind_q == KIND_EXT_REMOTE);
  assign rem     = (kind_q == KIND_STD_REMOTE) || (kind_q == KIND_EXT_REMOTE);
  assign ndig    = ext ? EXT_ID_DIGITS : STD_ID_DIGITS;
  assign pos_inc = pos_q + PW'(1);
  assign d_full  = pos_q - PW'(ndig) - PW'(2);
  assign nib     = d_full[3:0] ^ 4'd1;   // even digit is the high nibble

  // A line end stalls only when the result queue has no room.
  assign take           = item_valid_i && (!item_i.is_cr || !res_full_i);
  assign ctl_o.item_pop = take;
  assign ctl_o.res_push = take && item_i.is_cr && !skip_q;

  always_comb begin
    res_o = '0;
    if (kind_q == KIND_NONE) begin
      res_o.status = STAT_NONE;
    end else begin
      res_o.is_extended = ext;
      res_o.is_remote   = rem;
      if (bad_q || pos_q != PW'(ndig) + PW'(2) + PW'({len_q, 1'b0})) begin
        res_o.status = STAT_BAD;
      end else begin
        res_o.status      = STAT_OK;
        res_o.frame_id    = id_q;
        res_o.data_length = len_q;
        res_o.payload     = pay_q;
      end
    end
  end

  always_comb begin
    pos_d  = pos_q;
    kind_d = kind_q;
    bad_d  = bad_q;
    skip_d = skip_q;
    id_d   = id_q;
    len_d  = len_q;
    pay_d  = pay_q;
    if (take) begin
      if (item_i.is_cr) begin
        skip_d = 1'b0;
        pos_d  = '0;
        kind_d = KIND_NONE;
        bad_d  = 1'b0;
        id_d   = '0;
        len_d  = '0;
        pay_d  = '0;
      end else if (!skip_q) begin
        if (pos_q == '0) begin
          kind_d = item_i.kind;
        end else if (kind_q != KIND_NONE && !bad_q) begin
          if (pos_q <= PW'(ndig)) begin
            if (item_i.hex_ok) begin
              id_d = {id_q[27:0], item_i.hex_val};
            end else begin
              bad_d = 1'b1;
            end
          end else if (pos_q == PW'(ndig) + PW'(1)) begin
            if (item_i.len_ok) begin
              len_d = item_i.len_val;
            end else begin
              bad_d = 1'b1;
            end
          end else if (d_full >= PW'({len_q, 1'b0}) || !item_i.hex_ok) begin
            bad_d = 1'b1;
          end else begin
            for (int i = 0; i < 16; i++) begin
              if (nib == 4'(i)) begin
                pay_d[4*i +: 4] = pay_q[4*i +: 4] | item_i.hex_val;
              end
            end
          end
        end
        pos_d = pos_inc;
        if (pos_inc == PW'(LINE_BYTES)) begin
          // line too long: drop it up to the next carriage return
          pos_d  = '0;
          kind_d = KIND_NONE;
          bad_d  = 1'b0;
          id_d   = '0;
          len_d  = '0;
          pay_d  = '0;
          skip_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      kind_q <= KIND_NONE;
      bad_q  <= 1'b0;
      skip_q <= 1'b0;
      id_q   <= '0;
      len_q  <= '0;
      pay_q  <= '0;
    end else begin
      pos_q  <= pos_d;
      kind_q <= kind_d;
      bad_q  <= bad_d;
      skip_q <= skip_d;
      id_q   <= id_d;
      len_q  <= len_d;
      pay_q  <= pay_d;
    end
  end

endmodule

FILE: src/slcan_frame_command_parser_core.sv
// Top level of the ASCII CAN frame command line parser.
//
//  channel | direction | handshake             | fields
//  --------+-----------+-----------------------+-------------------------------------
//  input   | in        | push / full           | char_in_i
//  result  | out       | pop / empty           | status_o, is_extended_o, is_remote_o,
//          |           |                       | frame_id_o, data_length_o, payload_o
//
// One byte per cycle sustained while no line end waits on a full result queue: the line
// parser updates its accumulators as each item is taken, so an item can follow in every
// cycle. A line end passes through the byte queue, then the result queue, to the result side.
// Reset clears both queues and the line state; no clearing pass is needed.
// full only rises when the byte queue is full, which happens when results are not popped
// and the result queue backs up behind a carriage return.
`timescale 1ns / 1ps
`include "slcan_frame_command_parser_core_assert.svh"
module slcan_frame_command_parser_core #(
  parameter int LINE_BYTES  = 32,  // bytes before a line is dropped, 28 to 256
  parameter int BYTE_DEPTH  = 2,   // decoded bytes held between front and back
  parameter int RES_DEPTH   = 2    // finished lines waiting to be popped
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  char_in_i,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  status_o,
  output logic        is_extended_o,
  output logic        is_remote_o,
  output logic [31:0] frame_id_o,
  output logic [3:0]  data_length_o,
  output logic [63:0] payload_o
);
  import scfp_pkg::*;

  cls_t      cls_in, cls_head;
  res_t      res_new, res_head;
  back_ctl_t back_ctl;
  logic      byte_empty, res_full;

  // front: decode the byte as it is taken
  scfp_classify u_classify (
    .char_i (char_in_i),
    .cls_o  (cls_in)
  );

  // decoupling queue between decoder and line parser
  scfp_fifo #(
    .WIDTH ($bits(cls_t)),
    .DEPTH (BYTE_DEPTH)
  ) u_byte_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (push),
    .wdata_i (cls_in),
    .rd_i    (back_ctl.item_pop),
    .rdata_o (cls_head),
    .full_o  (full),
    .empty_o (byte_empty)
  );

  // back: line state and result forming
  scfp_line #(
    .LINE_BYTES (LINE_BYTES)
  ) u_line (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (!byte_empty),
    .item_i       (cls_head),
    .res_full_i   (res_full),
    .res_o        (res_new),
    .ctl_o        (back_ctl)
  );

  // results wait here until popped
  scfp_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (RES_DEPTH)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (back_ctl.res_push),
    .wdata_i (res_new),
    .rd_i    (pop),
    .rdata_o (res_head),
    .full_o  (res_full),
    .empty_o (empty)
  );

  assign status_o      = res_head.status;
  assign is_extended_o = res_head.is_extended;
  assign is_remote_o   = res_head.is_remote;
  assign frame_id_o    = res_head.frame_id;
  assign data_length_o = res_head.data_length;
  assign payload_o     = res_head.payload;

  `SCFP_ASSERT_IMP(a_res_room, clk_i, rst_ni, back_ctl.res_push, !res_full, "result pushed into full queue")
  `SCFP_ASSERT_IMP(a_res_from_byte, clk_i, rst_ni, back_ctl.res_push, back_ctl.item_pop && !byte_empty, "result without a line end")
  `SCFP_ASSERT_NXT(a_byte_held, clk_i, rst_ni, push && !full, !byte_empty, "accepted byte lost")
  `SCFP_ASSERT_IMP(a_status_code, clk_i, rst_ni, !empty, status_o != 2'd3, "undefined status code")

endmodule
